// ===== rtl/core/mexp_pkg.sv =====
// Package: word width, item payload types and sequencer states for modular exponentiation.
package mexp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word base;
        t_word exponent;
        t_word modulus;
    } t_mexp_in;

    typedef struct packed {
        t_word power_mod;
    } t_mexp_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_LOOP,
        S_MUL,
        S_FIN
    } t_mexp_state;

endpackage

// ===== rtl/core/mexp_in_if.sv =====
// Interface: input item channel (valid, ready, base/exponent/modulus payload).
interface mexp_in_if;
    import mexp_pkg::*;

    logic     valid;
    logic     ready;
    t_mexp_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mexp_out_if.sv =====
// Interface: result item channel (valid, ready, power_mod payload).
interface mexp_out_if;
    import mexp_pkg::*;

    logic      valid;
    logic      ready;
    t_mexp_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Per item: base reduction (skipped for a zero modulus), then modular products, each begun from S_LOOP, then S_FIN.
// Up to 2*W products per item, W = WORD_WIDTH.
// Throughput: one item at a time; the shared double-add-reduce unit handles one bit a cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops any pending result.
module modular_exponentiation_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mexp_in_if.sink       i_in,
    mexp_out_if.source    o_out
);
    import mexp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    t_mexp_state      r_state, n_state;
    t_word            r_acc, n_acc;
    t_word            r_sq, n_sq;
    t_word            r_exp, n_exp;
    t_word            r_mod, n_mod;
    t_word            r_y, n_y;
    t_word            r_red, n_red;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_dst_sq, n_dst_sq;
    logic             r_out_valid, n_out_valid;
    t_word            r_res, n_res;

    logic [WORD_WIDTH+1:0] w_addend;
    logic [WORD_WIDTH+1:0] w_sum;
    logic [WORD_WIDTH+1:0] w_m1;
    logic [WORD_WIDTH+1:0] w_m2;
    logic [WORD_WIDTH+1:0] w_diff;
    t_word                 w_step;
    logic                  w_in_acc;
    logic                  w_out_free;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Shared unit: 2*red + addend, then bring back below the modulus (sum < 3m)
    always_comb begin
        if (r_state == S_RED) begin
            w_addend = {{(WORD_WIDTH+1){1'b0}}, r_y[WORD_WIDTH-1]};
        end else begin
            w_addend = r_y[WORD_WIDTH-1] ? {2'b00, r_sq} : '0;
        end
        w_sum = {1'b0, r_red, 1'b0} + w_addend;
        w_m1  = {2'b00, r_mod};
        w_m2  = {1'b0, r_mod, 1'b0};
        priority if (w_sum >= w_m2) begin
            w_diff = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_diff = w_sum - w_m1;
        end else begin
            w_diff = w_sum;
        end
        w_step = w_diff[WORD_WIDTH-1:0];
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_mod       = r_mod;
        n_y         = r_y;
        n_red       = r_red;
        n_cnt       = r_cnt;
        n_dst_sq    = r_dst_sq;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mod = i_in.payload.modulus;
                    n_exp = i_in.payload.exponent;
                    n_y   = i_in.payload.base;
                    n_red = '0;
                    n_cnt = CNT_LAST;
                    n_sq  = '0;
                    if (i_in.payload.modulus == '0) begin
                        // no arithmetic on a zero modulus: answer zero
                        n_acc   = '0;
                        n_exp   = '0;
                        n_state = S_LOOP;
                    end else begin
                        n_acc   = (i_in.payload.modulus == t_word'(1)) ? '0 : t_word'(1);
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                // reduce the base one bit a cycle, most significant first
                n_red = w_step;
                n_y   = {r_y[WORD_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_sq    = w_step;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                n_red = '0;
                n_cnt = CNT_LAST;
                priority if (r_exp == '0) begin
                    n_state = S_FIN;
                end else if (r_sq == '0) begin
                    n_acc   = '0;
                    n_state = S_FIN;
                end else if (r_sq == t_word'(1)) begin
                    n_state = S_FIN;
                end else if (r_exp[0]) begin
                    n_y      = r_acc;
                    n_dst_sq = 1'b0;
                    n_exp    = r_exp - t_word'(1);
                    n_state  = S_MUL;
                end else begin
                    n_y      = r_sq;
                    n_dst_sq = 1'b1;
                    n_exp    = r_exp >> 1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                // double-and-add product by the running square, one bit a cycle
                n_red = w_step;
                n_y   = {r_y[WORD_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (r_dst_sq) begin
                        n_sq = w_step;
                    end else begin
                        n_acc = w_step;
                    end
                    n_state = S_LOOP;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_res       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_exp    <= n_exp;
        r_mod    <= n_mod;
        r_y      <= n_y;
        r_red    <= n_red;
        r_cnt    <= n_cnt;
        r_dst_sq <= n_dst_sq;
        r_res    <= n_res;
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.payload.power_mod = r_res;

endmodule

// ===== rtl/core/mexp_checker.sv =====
// Checker: port-level assertions for the modular exponentiation unit, with its bind.
module mexp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input mexp_pkg::t_word      i_power_mod
);
    import mexp_pkg::*;

    // a taken item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // results lie below a nonzero modulus and are zero for a zero modulus, so never all ones
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_power_mod != '1))
        else $error("result out of range");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // stalled result holds its value
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_power_mod))
        else $error("result changed while stalled");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_power_mod (o_out.payload.power_mod)
);
